FILE: rtl/dvoc_pkg.sv
// ----------------------------------------------------------------------------
// dvoc_pkg
// Shared widths, defaults and controller/datapath interface types for the
// distinct value occurrence counter.
// ----------------------------------------------------------------------------
package dvoc_pkg;

   localparam int VALUE_W       = 32;   // element value width
   localparam int OCC_W         = 7;    // occurrence count width
   localparam int MAX_ITEMS_DEF = 64;   // default table capacity
   localparam int RSP_DATA_W    = ((VALUE_W + OCC_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - VALUE_W - OCC_W;

   // controller -> datapath
   typedef struct packed {
      logic in_ready;    // request port open
      logic capture;     // take request into the work registers
      logic idx_clear;   // restart table index
      logic idx_inc;     // advance table index
      logic rd_en;       // read table entry at index
      logic wr_inc;      // bump count of entry at index
      logic wr_new;      // append new entry at end of table
      logic load_out;    // load result register from read data
      logic clear_seq;   // end of sequence: drop table contents
   } dvoc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;         // capacity of this sequence used up
      logic at_end;       // index reached number of entries
      logic match;        // read entry holds the held value
      logic last;         // held request closes the sequence
      logic final_entry;  // index points at the last entry
      logic out_busy;     // result register cannot take a new result
   } dvoc_status_type;

endpackage

FILE: rtl/distinct_value_occurrence_counter_core.sv
// ----------------------------------------------------------------------------
// distinct_value_occurrence_counter_core
// Counts how often each distinct value of a request sequence appears and
// reports value/count pairs in first-appearance order after the last request.
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                          | tlast          | tuser
//   --------+-----+--------------------------------+----------------+-----------
//   req_    | in  | [31:0] value                   | is_last        | -
//   rsp_    | out | [31:0] distinct_value,         | final_result   | overflowed
//           |     | [38:32] occurrences, [39] zero |                |
//
// A request is compared against the held table entries one by one, each
// entry read then compared; a match bumps that entry's count, else the value
// is appended; the single read port of the entry table sets this order.
// Reporting reads each distinct value and then loads it as a result.
// Reset clears the sequence counters and the result valid flag; the table
// itself is not cleared, its fill count marks the valid entries.
// A stalled result holds in the output register; the report walk pauses
// on it, and after the final result goes in the next request is taken.
// Requests past MAX_ITEMS in one sequence are dropped and set overflowed.
//
module distinct_value_occurrence_counter_core #(
   parameter int MAX_ITEMS = dvoc_pkg::MAX_ITEMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // [31:0] value
   input  logic                             req_tlast,   // is_last
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dvoc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] value, [38:32] count
   output logic                             rsp_tlast,   // final_result
   output logic                             rsp_tuser    // overflowed
);

   dvoc_pkg::dvoc_cmd_type             cmd;
   dvoc_pkg::dvoc_status_type          status;
   logic [dvoc_pkg::VALUE_W-1:0]       rsp_value;
   logic [dvoc_pkg::OCC_W-1:0]         rsp_occ;

   dvoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .cmd       (cmd)
   );

   dvoc_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_value (req_tdata[dvoc_pkg::VALUE_W-1:0]),
      .req_last  (req_tlast),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_value (rsp_value),
      .rsp_occ   (rsp_occ),
      .rsp_final (rsp_tlast),
      .rsp_ovf   (rsp_tuser)
   );

   // request port open only while the sequencer waits for work
   assign req_tready = cmd.in_ready;

   // pack result: value low, count above, zero fill to the byte
   assign rsp_tdata = {{dvoc_pkg::RSP_PAD_W{1'b0}}, rsp_occ, rsp_value};

endmodule

FILE: rtl/dvoc_ram.sv
// ----------------------------------------------------------------------------
// dvoc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dvoc_ram #(
   parameter int WIDTH = dvoc_pkg::VALUE_W,
   parameter int DEPTH = dvoc_pkg::MAX_ITEMS_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dvoc_ctrl.sv
// ----------------------------------------------------------------------------
// dvoc_ctrl
// Sequencer: takes a request, scans the table entry by entry, updates or
// appends, and on the closing request walks the table out as results.
// ----------------------------------------------------------------------------
module dvoc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  dvoc_pkg::dvoc_status_type status,
   output dvoc_pkg::dvoc_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CMP = 3'd2;
   localparam logic [2:0] S_REP_RD   = 3'd3;
   localparam logic [2:0] S_REP_OUT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.idx_clear = 1'b1;
               if (!status.full) begin
                  state_in = S_SCAN_RD;
               end else if (status.last) begin
                  state_in = S_REP_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (status.at_end) begin
               // no match found: append
               cmd.wr_new    = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = status.last ? S_REP_RD : S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (status.match) begin
               cmd.wr_inc    = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = status.last ? S_REP_RD : S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_REP_RD: begin
            if (status.at_end) begin
               // empty table: nothing to report
               cmd.clear_seq = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_REP_OUT;
            end
         end
         S_REP_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               if (status.final_entry) begin
                  cmd.clear_seq = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_REP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/dvoc_datapath.sv
// ----------------------------------------------------------------------------
// dvoc_datapath
// Work registers, entry table, sequence counters and the result register.
// ----------------------------------------------------------------------------
module dvoc_datapath #(
   parameter int MAX_ITEMS = dvoc_pkg::MAX_ITEMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dvoc_pkg::dvoc_cmd_type          cmd,
   output dvoc_pkg::dvoc_status_type       status,
   input  logic [dvoc_pkg::VALUE_W-1:0]    req_value,
   input  logic                            req_last,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [dvoc_pkg::VALUE_W-1:0]    rsp_value,
   output logic [dvoc_pkg::OCC_W-1:0]      rsp_occ,
   output logic                            rsp_final,
   output logic                            rsp_ovf
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int VW    = dvoc_pkg::VALUE_W;
   localparam int OW    = dvoc_pkg::OCC_W;
   localparam int ENT_W = VW + OW;

   logic [VW-1:0]    value_ff;
   logic             last_ff;
   logic [CNT_W-1:0] items_ff,  items_in;
   logic [CNT_W-1:0] total_ff,  total_in;
   logic [CNT_W-1:0] idx_ff,    idx_in;
   logic             drop_ff,   drop_in;
   logic             out_valid_ff, out_valid_in;
   logic [VW-1:0]    out_value_ff;
   logic [OW-1:0]    out_occ_ff;
   logic             out_final_ff;
   logic             out_ovf_ff;

   logic [CNT_W-1:0] idx_next;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [ENT_W-1:0] rd_data;
   logic [OW-1:0]    rd_occ;

   assign idx_next = idx_ff + CNT_W'(1);
   assign rd_occ   = rd_data[ENT_W-1:VW];

   // entry layout: count above value
   assign wr_en   = cmd.wr_new | cmd.wr_inc;
   assign wr_addr = cmd.wr_new ? total_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_new ? {OW'(1), value_ff} : {rd_occ + OW'(1), value_ff};

   dvoc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ITEMS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      items_in     = items_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      drop_in      = drop_ff;
      out_valid_in = out_valid_ff;
      if (cmd.capture) begin
         if (status.full) begin
            drop_in = 1'b1;
         end else begin
            items_in = items_ff + CNT_W'(1);
         end
      end
      if (cmd.wr_new) begin
         total_in = total_ff + CNT_W'(1);
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      if (cmd.clear_seq) begin
         items_in = '0;
         total_in = '0;
         drop_in  = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff     <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         items_ff     <= items_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_value;
         last_ff  <= req_last;
      end
      if (cmd.load_out) begin
         out_value_ff <= rd_data[VW-1:0];
         out_occ_ff   <= rd_occ;
         out_final_ff <= status.final_entry;
         out_ovf_ff   <= drop_ff;
      end
   end

   assign status.full        = (items_ff == CNT_W'(MAX_ITEMS));
   assign status.at_end      = (idx_ff == total_ff);
   assign status.match       = (rd_data[VW-1:0] == value_ff);
   assign status.last        = cmd.capture ? req_last : last_ff;
   assign status.final_entry = (idx_next == total_ff);
   assign status.out_busy    = out_valid_ff & ~rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_occ   = out_occ_ff;
   assign rsp_final = out_final_ff;
   assign rsp_ovf   = out_ovf_ff;

endmodule

FILE: rtl/dvoc_checker.sv
// ----------------------------------------------------------------------------
// dvoc_checker
// Port-level checks of the occurrence counter, bound to the top level.
// ----------------------------------------------------------------------------
module dvoc_checker #(
   parameter int MAX_ITEMS = dvoc_pkg::MAX_ITEMS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dvoc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   localparam int VW = dvoc_pkg::VALUE_W;
   localparam int OW = dvoc_pkg::OCC_W;

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // every reported count lies between one and the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[VW+OW-1:VW] != '0
         && rsp_tdata[VW+OW-1:VW] <= OW'(MAX_ITEMS))
      else $error("reported count out of range");

   // no request is taken in the middle of a report
   a_no_take_mid_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request port open during report");

   // the closing request of a sequence closes the request port
   a_close_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request port open right after closing request");

endmodule

bind distinct_value_occurrence_counter_core dvoc_checker #(
   .MAX_ITEMS (MAX_ITEMS)
) u_dvoc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
